/* sv/rlr_pkg.sv */
// shared types and constants for the resonant lowpass with coefficient ramps
`timescale 1ns / 1ps
`default_nettype none

package rlr_pkg;

	localparam int COEF_BITS     = 32;
	localparam int DAMP_BITS     = 31;
	localparam int RAMP_LEN_BITS = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int Q_FRAC        = 30;
	localparam int RAMP_SUM_BITS = 34;

	localparam logic [CFG_IDX_BITS-1:0] REG_CUTOFF_START     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING_START    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CUTOFF_STEP      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING_STEP     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CUTOFF_RAMP_LEN  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING_RAMP_LEN = 3'd5;

	localparam logic signed [RAMP_SUM_BITS-1:0] CUTOFF_MAX  = 34'sh0_8000_0000;
	localparam logic signed [RAMP_SUM_BITS-1:0] DAMPING_MAX = 34'sh0_4000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_ABS,
		ST_MLO,
		ST_MHI,
		ST_RND,
		ST_VEL,
		ST_POS,
		ST_DAMP,
		ST_OUT
	} rlr_state_t;

	typedef struct packed {
		logic load;
		logic lo;
		logic hi;
		logic rnd;
	} mul_ctl_t;

endpackage

`default_nettype wire

/* sv/rlr_ifs.sv */
// handshake channels: sample input, result output and register writes
`timescale 1ns / 1ps
`default_nettype none

interface rlr_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic signed [SAMPLE_BITS-1:0] mix_in;
	logic                          block_last;

	modport source (output valid, in_sample, mix_in, block_last, input ready);
	modport sink (input valid, in_sample, mix_in, block_last, output ready);
endinterface

interface rlr_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic                          clipped;

	modport source (output valid, out_sample, clipped, input ready);
	modport sink (input valid, out_sample, clipped, output ready);
endinterface

interface rlr_cfg_if import rlr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/rlr_mulq30.sv */
// iterative signed by Q30 multiplier on one 32x32 unit, rounded and saturated
`timescale 1ns / 1ps
`default_nettype none

module rlr_mulq30 import rlr_pkg::*; #(
	parameter int STATE_BITS = 40
) (
	input  logic                          clk,
	input  mul_ctl_t                      ctl,
	input  logic signed [STATE_BITS-1:0]  x,
	input  logic [COEF_BITS-1:0]          coef,
	output logic                          neg,
	output logic [STATE_BITS-1:0]         mag
);

	localparam int ACC_W = STATE_BITS + COEF_BITS;
	localparam int RND_W = ACC_W - Q_FRAC + 1;
	localparam logic [RND_W-1:0] LIM = RND_W'(1) << (STATE_BITS - 1);

	logic                      neg_q;
	logic [STATE_BITS-1:0]     m_q;
	logic [ACC_W-1:0]          acc_q;
	logic [STATE_BITS-1:0]     mag_q;
	logic [2*COEF_BITS-1:0]    m_wide;
	logic [COEF_BITS-1:0]      mul_a;
	logic [2*COEF_BITS-1:0]    prod;
	logic [RND_W-1:0]          rnd;
	logic [RND_W-1:0]          cap;

	assign m_wide = (2*COEF_BITS)'(m_q);
	assign mul_a  = ctl.hi ? m_wide[2*COEF_BITS-1:COEF_BITS] : m_wide[COEF_BITS-1:0];
	assign prod   = mul_a * coef;

	// round half away from zero on the magnitude, then cap per sign
	assign rnd = RND_W'(acc_q[ACC_W-1:Q_FRAC]) + RND_W'(acc_q[Q_FRAC-1]);
	assign cap = neg_q ? LIM : LIM - RND_W'(1);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			neg_q <= x[STATE_BITS-1];
			m_q   <= x[STATE_BITS-1] ? STATE_BITS'(-x) : STATE_BITS'(x);
		end
		if (ctl.lo) begin
			acc_q <= ACC_W'(prod);
		end
		if (ctl.hi) begin
			acc_q <= acc_q + (ACC_W'(prod) << COEF_BITS);
		end
		if (ctl.rnd) begin
			mag_q <= (rnd > cap) ? STATE_BITS'(cap) : STATE_BITS'(rnd);
		end
	end

	assign neg = neg_q;
	assign mag = mag_q;

endmodule

`default_nettype wire

/* sv/resonant_lowpass_with_ramps_top.sv */
// two-pole resonant lowpass with ramped cutoff and damping, top level
// Channels: samples (sink) carries in_sample, mix_in and block_last; results
// (source) carries out_sample and clipped; cfg takes register writes (index,
// data) and is always ready. A write to any listed register reloads the running
// cutoff, damping and both ramp counters; filter state is kept. Writes are
// expected only while no sample is in flight.
// Timing: one sample word in gives one result word out. After acceptance the
// sequencer walks 13 steps (difference, a cutoff multiply pass, velocity and
// position updates, a damping multiply pass and update, output), and a new word
// is taken only once the sequencer is back in idle. The pace is set by the
// single 32x32 multiplier, used twice per product, and the single saturating
// adder that all state sums share.
// Stall: the result sits in an output register; a new sample is still taken
// while it waits, and the sequencer only holds in its last step if the old
// result has not been taken yet.
// Reset: arst_n clears the filter state, coefficients, counters and registers.
`timescale 1ns / 1ps
`default_nettype none

module resonant_lowpass_with_ramps_top import rlr_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int STATE_BITS  = 40,
	parameter int RAMP_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rlr_cfg_if.sink    cfg,
	rlr_in_if.sink     samples,
	rlr_out_if.source  results
);

	localparam int STATE_FRAC = STATE_BITS - SAMPLE_BITS - 2;
	localparam int ADD_W      = STATE_BITS + 2;
	localparam int SUM_W      = SAMPLE_BITS + 3;

	rlr_state_t state_q, state_d;
	mul_ctl_t   mul_ctl;
	logic       pass_q;
	logic       in_ready;
	logic       out_free;
	logic       out_load;

	// configuration registers and running coefficients
	logic [COEF_BITS-1:0]        cutoff_start_q, cutoff_start_d;
	logic [DAMP_BITS-1:0]        damping_start_q, damping_start_d;
	logic [COEF_BITS-1:0]        cutoff_step_q, cutoff_step_d;
	logic [COEF_BITS-1:0]        damping_step_q, damping_step_d;
	logic [RAMP_LEN_BITS-1:0]    cutoff_len_q, cutoff_len_d;
	logic [RAMP_LEN_BITS-1:0]    damping_len_q, damping_len_d;
	logic                        cfg_hit;
	logic [COEF_BITS-1:0]        cutoff_now_q;
	logic [DAMP_BITS-1:0]        damping_now_q;
	logic [RAMP_BITS-1:0]        cutoff_left_q;
	logic [RAMP_BITS-1:0]        damping_left_q;
	logic signed [RAMP_SUM_BITS-1:0] cut_sum;
	logic signed [RAMP_SUM_BITS-1:0] damp_sum;
	logic [COEF_BITS-1:0]        cut_next;
	logic [DAMP_BITS-1:0]        damp_next;

	// filter state and datapath
	logic signed [SAMPLE_BITS-1:0] in_sample_q;
	logic signed [SAMPLE_BITS-1:0] mix_in_q;
	logic signed [STATE_BITS-1:0]  vel_q;
	logic signed [STATE_BITS-1:0]  pos_q;
	logic signed [STATE_BITS-1:0]  diff_q;
	logic signed [STATE_BITS:0]    add_a;
	logic signed [STATE_BITS:0]    add_b;
	logic                          add_sub;
	logic signed [ADD_W-1:0]       add_sum;
	logic signed [STATE_BITS-1:0]  add_res;
	logic signed [STATE_BITS:0]    scaled;
	logic signed [STATE_BITS-1:0]  mul_x;
	logic [COEF_BITS-1:0]          mul_coef;
	logic                          mul_neg;
	logic [STATE_BITS-1:0]         mul_mag;

	// output path
	logic signed [SAMPLE_BITS+1:0] pos_whole;
	logic signed [SUM_W-1:0]       out_sum;
	logic                          out_over;
	logic signed [SAMPLE_BITS-1:0] out_sat;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          clipped_q;

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (samples.valid) state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_ABS;
			ST_ABS:  state_d = ST_MLO;
			ST_MLO:  state_d = ST_MHI;
			ST_MHI:  state_d = ST_RND;
			ST_RND:  state_d = pass_q ? ST_DAMP : ST_VEL;
			ST_VEL:  state_d = ST_POS;
			ST_POS:  state_d = ST_ABS;
			ST_DAMP: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mul_ctl  = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_ABS:  mul_ctl.load = 1'b1;
			ST_MLO:  mul_ctl.lo = 1'b1;
			ST_MHI:  mul_ctl.hi = 1'b1;
			ST_RND:  mul_ctl.rnd = 1'b1;
			ST_OUT:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_ready && samples.valid) pass_q <= 1'b0;
			else if (state_q == ST_POS) pass_q <= 1'b1;
		end
	end

	assign samples.ready = in_ready;

	always_ff @(posedge clk) begin
		if (in_ready && samples.valid) begin
			in_sample_q <= samples.in_sample;
			mix_in_q    <= samples.mix_in;
		end
	end

	// ---------------------------------------------------------------
	// shared saturating adder
	// ---------------------------------------------------------------
	assign scaled = (STATE_BITS+1)'(in_sample_q) <<< STATE_FRAC;

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			ST_DIFF: begin
				add_a   = scaled;
				add_b   = (STATE_BITS+1)'(pos_q);
				add_sub = 1'b1;
			end
			ST_VEL: begin
				add_a   = (STATE_BITS+1)'(vel_q);
				add_b   = $signed({1'b0, mul_mag});
				add_sub = mul_neg;
			end
			ST_POS: begin
				add_a = (STATE_BITS+1)'(pos_q);
				add_b = (STATE_BITS+1)'(vel_q);
			end
			ST_DAMP: begin
				add_b   = $signed({1'b0, mul_mag});
				add_sub = mul_neg;
			end
			default: ;
		endcase
	end

	assign add_sum = add_sub ? ADD_W'(add_a) - ADD_W'(add_b) : ADD_W'(add_a) + ADD_W'(add_b);

	// fits when the bits above the state sign all agree with it
	always_comb begin
		if (add_sum[ADD_W-1:STATE_BITS-1] == '0 || add_sum[ADD_W-1:STATE_BITS-1] == '1)
			add_res = add_sum[STATE_BITS-1:0];
		else if (add_sum[ADD_W-1])
			add_res = {1'b1, {(STATE_BITS-1){1'b0}}};
		else
			add_res = {1'b0, {(STATE_BITS-1){1'b1}}};
	end

	// ---------------------------------------------------------------
	// shared multiplier: cutoff pass first, then damping
	// ---------------------------------------------------------------
	assign mul_x    = pass_q ? vel_q : diff_q;
	assign mul_coef = pass_q ? {1'b0, damping_now_q} : cutoff_now_q;

	rlr_mulq30 #(
		.STATE_BITS(STATE_BITS)
	) u_mul (
		.clk  (clk),
		.ctl  (mul_ctl),
		.x    (mul_x),
		.coef (mul_coef),
		.neg  (mul_neg),
		.mag  (mul_mag)
	);

	// ---------------------------------------------------------------
	// output rounding and saturation
	// ---------------------------------------------------------------
	assign pos_whole = pos_q[STATE_BITS-1:STATE_FRAC];
	assign out_sum   = SUM_W'(pos_whole) + SUM_W'(mix_in_q)
		+ $signed({{(SUM_W-1){1'b0}}, pos_q[STATE_FRAC-1]});
	assign out_over  = !(out_sum[SUM_W-1:SAMPLE_BITS-1] == '0
		|| out_sum[SUM_W-1:SAMPLE_BITS-1] == '1);

	always_comb begin
		if (!out_over)
			out_sat = out_sum[SAMPLE_BITS-1:0];
		else if (out_sum[SUM_W-1])
			out_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			out_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	end

	// ---------------------------------------------------------------
	// coefficient ramps
	// ---------------------------------------------------------------
	assign cut_sum  = $signed({2'b00, cutoff_now_q}) + RAMP_SUM_BITS'($signed(cutoff_step_q));
	assign damp_sum = $signed({3'b000, damping_now_q})
		+ RAMP_SUM_BITS'($signed(damping_step_q));

	always_comb begin
		if (cut_sum < 0) cut_next = '0;
		else if (cut_sum > CUTOFF_MAX) cut_next = COEF_BITS'(CUTOFF_MAX);
		else cut_next = cut_sum[COEF_BITS-1:0];
		if (damp_sum < 0) damp_next = '0;
		else if (damp_sum > DAMPING_MAX) damp_next = DAMP_BITS'(DAMPING_MAX);
		else damp_next = damp_sum[DAMP_BITS-1:0];
	end

	// ---------------------------------------------------------------
	// register writes
	// ---------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_comb begin
		cutoff_start_d  = cutoff_start_q;
		damping_start_d = damping_start_q;
		cutoff_step_d   = cutoff_step_q;
		damping_step_d  = damping_step_q;
		cutoff_len_d    = cutoff_len_q;
		damping_len_d   = damping_len_q;
		cfg_hit         = 1'b0;
		if (cfg.valid) begin
			cfg_hit = 1'b1;
			unique case (cfg.index)
				REG_CUTOFF_START:     cutoff_start_d  = cfg.data;
				REG_DAMPING_START:    damping_start_d = DAMP_BITS'(cfg.data);
				REG_CUTOFF_STEP:      cutoff_step_d   = cfg.data;
				REG_DAMPING_STEP:     damping_step_d  = cfg.data;
				REG_CUTOFF_RAMP_LEN:  cutoff_len_d    = RAMP_LEN_BITS'(cfg.data);
				REG_DAMPING_RAMP_LEN: damping_len_d   = RAMP_LEN_BITS'(cfg.data);
				default:              cfg_hit         = 1'b0;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// state registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_start_q  <= '0;
			damping_start_q <= '0;
			cutoff_step_q   <= '0;
			damping_step_q  <= '0;
			cutoff_len_q    <= '0;
			damping_len_q   <= '0;
			cutoff_now_q    <= '0;
			damping_now_q   <= '0;
			cutoff_left_q   <= '0;
			damping_left_q  <= '0;
			vel_q           <= '0;
			pos_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			cutoff_start_q  <= cutoff_start_d;
			damping_start_q <= damping_start_d;
			cutoff_step_q   <= cutoff_step_d;
			damping_step_q  <= damping_step_d;
			cutoff_len_q    <= cutoff_len_d;
			damping_len_q   <= damping_len_d;

			if (state_q == ST_VEL || state_q == ST_DAMP) vel_q <= add_res;
			if (state_q == ST_POS) pos_q <= add_res;

			if (out_load) begin
				out_valid_q <= 1'b1;
				if (cutoff_left_q != '0) begin
					cutoff_now_q  <= cut_next;
					cutoff_left_q <= cutoff_left_q - 1'b1;
				end
				if (damping_left_q != '0) begin
					damping_now_q  <= damp_next;
					damping_left_q <= damping_left_q - 1'b1;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			// any listed register reloads the running coefficients
			if (cfg_hit) begin
				cutoff_now_q   <= cutoff_start_d;
				damping_now_q  <= damping_start_d;
				cutoff_left_q  <= RAMP_BITS'(cutoff_len_d);
				damping_left_q <= RAMP_BITS'(damping_len_d);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) diff_q <= add_res;
		if (out_load) begin
			out_sample_q <= out_sat;
			clipped_q    <= out_over;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.out_sample = out_sample_q;
	assign results.clipped    = clipped_q;

endmodule

`default_nettype wire

/* sv/rlr_checker.sv */
// port-level checks for the resonant lowpass, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rlr_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] out_sample,
	input logic                          clipped
);

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// a sample occupies the sequencer, so no second word right behind it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accepted word");

	// a new result is only produced from the busy final step
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a sample being processed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(clipped))
		else $error("stalled result word changed");

	// a saturated result must sit on a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> out_sample == S_MAX || out_sample == S_MIN)
		else $error("clip flag set on a value off the rails");

endmodule

bind resonant_lowpass_with_ramps_top rlr_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_rlr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_sample (results.out_sample),
	.clipped    (results.clipped)
);

`default_nettype wire
